[src/lzss_stream_compressor_macros.svh]
// Assertion macros shared by the compressor RTL
`ifndef LZSS_STREAM_COMPRESSOR_MACROS_SVH
`define LZSS_STREAM_COMPRESSOR_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define LZSS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Trigger at one edge implies the condition at the next edge
`define LZSS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[src/lzss_pkg.sv]
// Shared types, codes and length tables for the LZSS compressor
`timescale 1ns / 1ps

package lzss_pkg;

    localparam int MATCH_SPAN = 13;
    localparam logic [8:0] MARKER_WORD = 9'h0AB;
    localparam int FLUSH_BITS = 9;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_DICT  = 2'd1,
        FUNC_DATA  = 2'd2,
        FUNC_FLUSH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_WINDOW_BITS  = 2'd0,
        CFG_LITERAL_BITS = 2'd1,
        CFG_MIN_MATCH    = 2'd2,
        CFG_CUSTOM_DICT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SWAIT,
        S_SWAIT2,
        S_DECIDE,
        S_OFFSET,
        S_COMMIT,
        S_DRAIN,
        S_FLUSH_CHECK,
        S_MARKER,
        S_MDRAIN,
        S_PAD,
        S_END
    } state_t;

    // Broadcast controls for the lookahead cell row
    typedef struct packed {
        logic clr;
        logic step;
        logic pop;
        logic load;
    } row_ctrl_t;

    // Result request from the sequencer to the output stage
    typedef struct packed {
        logic       push;
        logic       fin;
        logic [7:0] data;
        logic       status;
    } emit_req_t;

    function automatic logic [8:0] len_code(input logic [3:0] idx);
        logic [8:0] c;
        case (idx)
            4'd0:    c = 9'h000;
            4'd1:    c = 9'h003;
            4'd2:    c = 9'h008;
            4'd3:    c = 9'h00B;
            4'd4:    c = 9'h014;
            4'd5:    c = 9'h024;
            4'd6:    c = 9'h026;
            4'd7:    c = 9'h02B;
            4'd8:    c = 9'h04B;
            4'd9:    c = 9'h054;
            4'd10:   c = 9'h094;
            4'd11:   c = 9'h095;
            4'd12:   c = 9'h0AA;
            4'd13:   c = 9'h027;
            default: c = 9'h000;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] len_bits(input logic [3:0] idx);
        logic [3:0] n;
        case (idx)
            4'd0:    n = 4'd2;
            4'd1:    n = 4'd3;
            4'd2:    n = 4'd5;
            4'd3:    n = 4'd5;
            4'd4:    n = 4'd6;
            4'd5:    n = 4'd7;
            4'd6:    n = 4'd7;
            4'd7:    n = 4'd7;
            4'd8:    n = 4'd8;
            4'd9:    n = 4'd8;
            4'd10:   n = 4'd9;
            4'd11:   n = 4'd9;
            4'd12:   n = 4'd9;
            4'd13:   n = 4'd7;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

[src/lzss_cell.sv]
// One lookahead cell: holds a lookahead byte and the running match bit
`timescale 1ns / 1ps

module lzss_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  lzss_pkg::row_ctrl_t ctrl,
    input  logic                load_sel,
    input  logic [7:0]          load_byte,
    input  logic [7:0]          right_byte,
    input  logic [7:0]          win_byte,
    input  logic                r_in,
    output logic [7:0]          la_byte,
    output logic                r_out
);

    logic [7:0] la_reg;
    logic       r_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && load_sel)
        begin
            la_reg <= load_byte;
        end
        else if (ctrl.pop)
        begin
            la_reg <= right_byte;
        end
    end

    // r: the window run ending at this byte matches lookahead[0..k]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            r_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            r_reg <= r_in && (win_byte == la_reg);
        end
    end

    assign la_byte = la_reg;
    assign r_out   = r_reg;

endmodule

[src/lzss_match_row.sv]
// Row of lookahead cells with earliest-longest match tracking
`timescale 1ns / 1ps

module lzss_match_row
#(
    parameter int AW    = 10,
    parameter int DEPTH = 16,
    localparam int CW   = $clog2(DEPTH + 1),
    localparam int KW   = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lzss_pkg::row_ctrl_t ctrl,
    input  logic [CW-1:0]       load_idx,
    input  logic [7:0]          load_byte,
    input  logic [7:0]          win_byte,
    input  logic [AW-1:0]       win_idx,
    input  logic [CW-1:0]       count,
    input  logic [4:0]          cap,
    output logic [7:0]          la0,
    output logic [CW-1:0]       best_len,
    output logic [AW-1:0]       best_pos
);

    logic [7:0]    la_b [DEPTH];
    logic          r_b  [DEPTH];
    logic          v2_reg;
    logic [AW-1:0] j2_reg;
    logic [CW-1:0] best_len_reg;
    logic [AW-1:0] best_pos_reg;
    logic          hit;
    logic [KW-1:0] hit_k;
    logic [CW-1:0] hit_len;
    logic [AW-1:0] hit_pos;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic [7:0] right;
            logic       rin;
            if (k == DEPTH - 1)
            begin : g_end
                assign right = 8'h00;
            end
            else
            begin : g_mid
                assign right = la_b[k+1];
            end
            if (k == 0)
            begin : g_first
                assign rin = 1'b1;
            end
            else
            begin : g_next
                assign rin = r_b[k-1];
            end
            lzss_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .load_sel   (load_idx == CW'(k)),
                .load_byte  (load_byte),
                .right_byte (right),
                .win_byte   (win_byte),
                .r_in       (rin),
                .la_byte    (la_b[k]),
                .r_out      (r_b[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= ctrl.step;
        end
    end

    always_ff @(posedge clk)
    begin
        j2_reg <= win_idx;
    end

    // longest live run among cells inside the fill and the length cap
    always_comb
    begin
        hit   = 1'b0;
        hit_k = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (r_b[i] && (count > CW'(i)) && ({1'b0, cap} >= 6'(i + 1)))
            begin
                hit   = 1'b1;
                hit_k = KW'(i);
            end
        end
    end

    assign hit_len = CW'(hit_k) + CW'(1);
    assign hit_pos = j2_reg - AW'(hit_k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_len_reg <= '0;
            best_pos_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            best_len_reg <= '0;
            best_pos_reg <= '0;
        end
        else if (v2_reg && hit && (hit_len > best_len_reg))
        begin
            best_len_reg <= hit_len;
            best_pos_reg <= hit_pos;
        end
    end

    assign la0      = la_b[0];
    assign best_len = best_len_reg;
    assign best_pos = best_pos_reg;

endmodule

[src/lzss_out.sv]
// Output stage: one held result plus the output register, marks tlast
`timescale 1ns / 1ps

module lzss_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  lzss_pkg::emit_req_t req,
    output logic                ready,
    input  logic                m_axis_tready,
    output logic                m_axis_tvalid,
    output logic [7:0]          m_axis_tdata,   // out_byte
    output logic                m_axis_tlast,   // last
    output logic [0:0]          m_axis_tuser    // status
);

    logic       pv_reg;
    logic [7:0] pd_reg;
    logic       ps_reg;
    logic       ov_reg;
    logic [7:0] od_reg;
    logic       ol_reg;
    logic       os_reg;
    logic       out_free;
    logic       move;

    assign out_free = !ov_reg || m_axis_tready;
    assign ready    = !pv_reg || out_free;
    // held result goes out when a newer one arrives or the request ends
    assign move     = pv_reg && (req.push || req.fin) && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (req.push && ready)
            begin
                pv_reg <= 1'b1;
            end
            else if (req.fin && ready)
            begin
                pv_reg <= 1'b0;
            end
            if (move)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push && ready)
        begin
            pd_reg <= req.data;
            ps_reg <= req.status;
        end
        if (move)
        begin
            od_reg <= pd_reg;
            os_reg <= ps_reg;
            ol_reg <= req.fin;
        end
    end

    assign m_axis_tvalid   = ov_reg;
    assign m_axis_tdata    = od_reg;
    assign m_axis_tlast    = ol_reg;
    assign m_axis_tuser[0] = os_reg;

endmodule

[src/lzss_stream_compressor.sv]
// LZSS stream compressor top: sequencer, window memory, bit packer
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser=func, tdata=byte/addr/marker
//  m_axis    out  tvalid/tready/tlast    tdata=out_byte, tuser=status
//  cfg       in   cfg_we                 cfg_addr=register, cfg_data=value
//
// Start drains the header byte and closes; a dictionary write or a data byte that
// does not fill the lookahead is taken and closed. A filling byte codes one token:
// accept, a scan of all 2^W window bytes (read in turn through the cell row),
// settle and decide, the offset of a match, a commit per consumed byte, the output
// bytes and a close. Flush repeats these steps while bytes remain. Reset takes
// effect at once. Output stalls hold the sequencer; input is taken only when idle.
`timescale 1ns / 1ps
`include "lzss_stream_compressor_macros.svh"

module lzss_stream_compressor
#(
    parameter int MAX_WINDOW_BITS = 10,
    parameter int LOOKAHEAD_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte, dict_address, flush_marker
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // last
    output logic [0:0]  m_axis_tuser,   // status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_data
);

    localparam int AW    = MAX_WINDOW_BITS;
    localparam int DEPTH = LOOKAHEAD_DEPTH;
    localparam int CW    = $clog2(DEPTH + 1);

    lzss_pkg::state_t    state_reg, state_next;
    lzss_pkg::row_ctrl_t ctrl;
    lzss_pkg::emit_req_t emit;
    lzss_pkg::func_t     in_func;
    logic                emit_ready;

    logic [3:0]    w_reg, l_reg, m_reg;
    logic          cd_reg;
    logic [3:0]    w_eff, l_eff, m_eff;
    logic [4:0]    cap;
    logic [AW-1:0] win_mask;

    logic [AW-1:0] wpos_reg, wpos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   acc_reg, acc_next;
    logic [5:0]    bitcnt_reg, bitcnt_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] len_reg, len_next;
    logic          flush_reg, flush_next;
    logic          marker_reg, marker_next;
    logic          v1_reg;
    logic [AW-1:0] j1_reg;
    logic [7:0]    mem_q_reg;

    logic [7:0]    win_mem [2**AW];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    logic [7:0]    la0;
    logic [CW-1:0] best_len;
    logic [AW-1:0] best_pos;

    logic          pb_en;
    logic [15:0]   pb_bits;
    logic [4:0]    pb_n;
    logic [5:0]    pb_sh;
    logic [7:0]    header;
    logic          lit_over;
    logic [8:0]    lit_word;
    logic [3:0]    len_idx;
    logic [7:0]    in_byte;
    logic [9:0]    in_addr;
    logic          in_marker;

    assign in_func   = lzss_pkg::func_t'(s_axis_tuser);
    assign in_byte   = s_axis_tdata[7:0];
    assign in_addr   = s_axis_tdata[17:8];
    assign in_marker = s_axis_tdata[18];

    // effective register values
    assign w_eff = (w_reg < 4'd8) ? 4'd8 :
                   ((w_reg > 4'(MAX_WINDOW_BITS)) ? 4'(MAX_WINDOW_BITS) : w_reg);
    assign l_eff = (l_reg < 4'd5) ? 4'd5 : ((l_reg > 4'd8) ? 4'd8 : l_reg);
    assign m_eff = (m_reg < 4'd1) ? 4'd1 : ((m_reg > 4'd8) ? 4'd8 : m_reg);
    assign cap      = 5'(m_eff) + 5'(lzss_pkg::MATCH_SPAN);
    assign win_mask = ~({AW{1'b1}} << w_eff);
    assign header   = {3'(w_eff - 4'd8), 2'(l_eff - 4'd5), cd_reg, 2'b00};
    assign lit_over = (la0 >> l_eff) != 8'd0;
    assign lit_word = (9'd1 << l_eff) | 9'(la0);
    assign len_idx  = 4'(6'(best_len) - 6'(m_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= 4'd10;
            l_reg  <= 4'd8;
            m_reg  <= 4'd2;
            cd_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (lzss_pkg::cfg_idx_t'(cfg_addr))
                lzss_pkg::CFG_WINDOW_BITS:  w_reg  <= cfg_data;
                lzss_pkg::CFG_LITERAL_BITS: l_reg  <= cfg_data;
                lzss_pkg::CFG_MIN_MATCH:    m_reg  <= cfg_data;
                lzss_pkg::CFG_CUSTOM_DICT:  cd_reg <= cfg_data[0];
                default:                    cd_reg <= cd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lzss_pkg::S_IDLE;
            wpos_reg    <= '0;
            count_reg   <= '0;
            acc_reg     <= '0;
            bitcnt_reg  <= '0;
            rd_addr_reg <= '0;
            len_reg     <= '0;
            flush_reg   <= 1'b0;
            marker_reg  <= 1'b0;
            v1_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            bitcnt_reg  <= bitcnt_next;
            rd_addr_reg <= rd_addr_next;
            len_reg     <= len_next;
            flush_reg   <= flush_next;
            marker_reg  <= marker_next;
            v1_reg      <= (state_reg == lzss_pkg::S_SEARCH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == lzss_pkg::S_SEARCH)
        begin
            mem_q_reg <= win_mem[rd_addr_reg];
        end
        j1_reg <= rd_addr_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        wpos_next     = wpos_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;
        bitcnt_next   = bitcnt_reg;
        rd_addr_next  = rd_addr_reg;
        len_next      = len_reg;
        flush_next    = flush_reg;
        marker_next   = marker_reg;
        ctrl          = '0;
        ctrl.step     = v1_reg;
        emit          = '0;
        pb_en         = 1'b0;
        pb_bits       = '0;
        pb_n          = '0;
        mem_we        = 1'b0;
        // position may exceed a window shrunk since the last start
        mem_waddr     = wpos_reg & win_mask;
        mem_wdata     = la0;
        s_axis_tready = 1'b0;

        case (state_reg)
            lzss_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    case (in_func)
                        lzss_pkg::FUNC_START:
                        begin
                            wpos_next   = '0;
                            count_next  = '0;
                            acc_next    = {header, 24'h000000};
                            bitcnt_next = 6'd8;
                            flush_next  = 1'b0;
                            state_next  = lzss_pkg::S_DRAIN;
                        end
                        lzss_pkg::FUNC_DICT:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(in_addr);
                            mem_wdata  = in_byte;
                            state_next = lzss_pkg::S_END;
                        end
                        lzss_pkg::FUNC_DATA:
                        begin
                            state_next = lzss_pkg::S_END;
                            if (count_reg < CW'(DEPTH))
                            begin
                                ctrl.load  = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (count_reg == CW'(DEPTH - 1))
                                begin
                                    flush_next   = 1'b0;
                                    ctrl.clr     = 1'b1;
                                    rd_addr_next = '0;
                                    state_next   = lzss_pkg::S_SEARCH;
                                end
                            end
                        end
                        lzss_pkg::FUNC_FLUSH:
                        begin
                            flush_next  = 1'b1;
                            marker_next = in_marker;
                            state_next  = lzss_pkg::S_FLUSH_CHECK;
                        end
                        default:
                        begin
                            state_next = lzss_pkg::S_END;
                        end
                    endcase
                end
            end

            lzss_pkg::S_SEARCH:
            begin
                if (rd_addr_reg == win_mask)
                begin
                    state_next = lzss_pkg::S_SWAIT;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end

            // SWAIT and SWAIT2 let the last byte pass the cells and the tracker
            lzss_pkg::S_SWAIT:
            begin
                state_next = lzss_pkg::S_SWAIT2;
            end

            lzss_pkg::S_SWAIT2:
            begin
                state_next = lzss_pkg::S_DECIDE;
            end

            lzss_pkg::S_DECIDE:
            begin
                if (6'(best_len) < 6'(m_eff))
                begin
                    if (lit_over)
                    begin
                        // byte does not fit: report and drop it
                        emit.push   = 1'b1;
                        emit.status = 1'b1;
                        if (emit_ready)
                        begin
                            ctrl.pop   = 1'b1;
                            count_next = count_reg - CW'(1);
                            state_next = flush_reg ? lzss_pkg::S_FLUSH_CHECK :
                                                     lzss_pkg::S_END;
                        end
                    end
                    else
                    begin
                        pb_en      = 1'b1;
                        pb_bits    = 16'(lit_word);
                        pb_n       = 5'(l_eff) + 5'd1;
                        len_next   = CW'(1);
                        state_next = lzss_pkg::S_COMMIT;
                    end
                end
                else
                begin
                    pb_en      = 1'b1;
                    pb_bits    = 16'(lzss_pkg::len_code(len_idx));
                    pb_n       = 5'(lzss_pkg::len_bits(len_idx));
                    len_next   = best_len;
                    state_next = lzss_pkg::S_OFFSET;
                end
            end

            lzss_pkg::S_OFFSET:
            begin
                pb_en      = 1'b1;
                pb_bits    = 16'(best_pos);
                pb_n       = 5'(w_eff);
                state_next = lzss_pkg::S_COMMIT;
            end

            lzss_pkg::S_COMMIT:
            begin
                mem_we     = 1'b1;
                wpos_next  = (wpos_reg + AW'(1)) & win_mask;
                ctrl.pop   = 1'b1;
                count_next = count_reg - CW'(1);
                len_next   = len_reg - CW'(1);
                if (len_reg == CW'(1))
                begin
                    state_next = lzss_pkg::S_DRAIN;
                end
            end

            lzss_pkg::S_DRAIN:
            begin
                if (bitcnt_reg >= 6'd8)
                begin
                    emit.push = 1'b1;
                    emit.data = acc_reg[31:24];
                    if (emit_ready)
                    begin
                        acc_next    = acc_reg << 8;
                        bitcnt_next = bitcnt_reg - 6'd8;
                    end
                end
                else
                begin
                    state_next = flush_reg ? lzss_pkg::S_FLUSH_CHECK : lzss_pkg::S_END;
                end
            end

            lzss_pkg::S_FLUSH_CHECK:
            begin
                if (count_reg != '0)
                begin
                    ctrl.clr     = 1'b1;
                    rd_addr_next = '0;
                    state_next   = lzss_pkg::S_SEARCH;
                end
                else if ((bitcnt_reg != '0) && marker_reg)
                begin
                    state_next = lzss_pkg::S_MARKER;
                end
                else
                begin
                    state_next = lzss_pkg::S_PAD;
                end
            end

            lzss_pkg::S_MARKER:
            begin
                pb_en      = 1'b1;
                pb_bits    = 16'(lzss_pkg::MARKER_WORD);
                pb_n       = 5'(lzss_pkg::FLUSH_BITS);
                state_next = lzss_pkg::S_MDRAIN;
            end

            lzss_pkg::S_MDRAIN:
            begin
                if (bitcnt_reg >= 6'd8)
                begin
                    emit.push = 1'b1;
                    emit.data = acc_reg[31:24];
                    if (emit_ready)
                    begin
                        acc_next    = acc_reg << 8;
                        bitcnt_next = bitcnt_reg - 6'd8;
                    end
                end
                else
                begin
                    state_next = lzss_pkg::S_PAD;
                end
            end

            lzss_pkg::S_PAD:
            begin
                if (bitcnt_reg != '0)
                begin
                    emit.push = 1'b1;
                    emit.data = acc_reg[31:24];
                    if (emit_ready)
                    begin
                        acc_next    = '0;
                        bitcnt_next = '0;
                        state_next  = lzss_pkg::S_END;
                    end
                end
                else
                begin
                    state_next = lzss_pkg::S_END;
                end
            end

            lzss_pkg::S_END:
            begin
                emit.fin = 1'b1;
                if (emit_ready)
                begin
                    state_next = lzss_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lzss_pkg::S_IDLE;
            end
        endcase

        // bit packer: new field lands just below the pending bits, MSB first
        if (pb_en)
        begin
            acc_next    = acc_reg | (32'(pb_bits) << pb_sh);
            bitcnt_next = bitcnt_reg + 6'(pb_n);
        end
    end

    assign pb_sh = 6'd32 - bitcnt_reg - 6'(pb_n);

    lzss_match_row
    #(
        .AW    (AW),
        .DEPTH (DEPTH)
    )
    u_row
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_idx  (count_reg),
        .load_byte (in_byte),
        .win_byte  (mem_q_reg),
        .win_idx   (j1_reg),
        .count     (count_reg),
        .cap       (cap),
        .la0       (la0),
        .best_len  (best_len),
        .best_pos  (best_pos)
    );

    lzss_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (emit),
        .ready         (emit_ready),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    `LZSS_ASSERT_ALWAYS(a_idle_bits, (state_reg != lzss_pkg::S_IDLE) || (bitcnt_reg < 6'd8), "bits left undrained at idle")
    `LZSS_ASSERT_ALWAYS(a_commit_len, (state_reg != lzss_pkg::S_COMMIT) || (len_reg != '0), "commit with zero length")
    `LZSS_ASSERT_ALWAYS(a_count_max, count_reg <= CW'(DEPTH), "lookahead count overflow")
    `LZSS_ASSERT_NEXT(a_fin_idle, emit.fin && emit_ready, state_reg == lzss_pkg::S_IDLE, "request end did not return to idle")

endmodule
